// ===== design/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the sorted page table: field widths,
// mode and status codes, the cell command set and the cell link structs.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

  localparam int KEY_W        = 52;
  localparam int STAMP_W      = 64;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_RANGE  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED    = 3'd0,
    STS_DUPLICATE   = 3'd1,
    STS_FULL        = 3'd2,
    STS_HIT         = 3'd3,
    STS_MISS        = 3'd4,
    STS_RANGE_ENTRY = 3'd5,
    STS_RANGE_EMPTY = 3'd6
  } status_t;

  // Command broadcast to every cell in the row
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_EVAL   = 3'd1,
    CMD_ARM    = 3'd2,
    CMD_SHIFT  = 3'd3,
    CMD_INSERT = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   range_end;
    logic [STAMP_W-1:0] stamp;
  } cell_ctl_t;

  // Handed from a cell to its right-hand neighbour
  typedef struct packed {
    logic               lt;
    logic               tok;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } cell_link_t;

  // Contribution of one cell to the read bus; all zero unless it holds the token
  typedef struct packed {
    logic               tok;
    logic               eq;
    logic               inr;
    logic               next_inr;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } cell_tap_t;

endpackage

`default_nettype wire

// ===== design/spt_cell.sv =====
// ----------------------------------------------------------------------------
// spt_cell
// One record slot of the sorted row. Holds a page and stamp, registers its
// compare flags against the current key, carries the read token and shifts
// right on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spt_pkg::cell_ctl_t ctl,
  input  wire logic               vld,
  input  wire spt_pkg::cell_link_t left,
  input  wire logic               right_inr,
  output spt_pkg::cell_link_t     self_link,
  output logic                    inr,
  output spt_pkg::cell_tap_t      tap
);

  logic [spt_pkg::KEY_W-1:0]   key_r,   key_nxt;
  logic [spt_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;
  logic lt_r,  lt_nxt;
  logic eq_r,  eq_nxt;
  logic le_r,  le_nxt;
  logic tok_r, tok_nxt;
  logic start;

  // in range: not below the start key and not above the end key
  assign inr = !lt_r && le_r;

  always_comb begin
    // first slot not below the key
    start     = left.lt && !lt_r && vld;
    key_nxt   = key_r;
    stamp_nxt = stamp_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    le_nxt    = le_r;
    tok_nxt   = tok_r;
    case (ctl.cmd)
      spt_pkg::CMD_EVAL: begin
        lt_nxt  = vld && (key_r <  ctl.key);
        eq_nxt  = vld && (key_r == ctl.key);
        le_nxt  = vld && (key_r <= ctl.range_end);
        tok_nxt = 1'b0;
      end
      spt_pkg::CMD_ARM: begin
        tok_nxt = start;
      end
      spt_pkg::CMD_SHIFT: begin
        tok_nxt = left.tok;
      end
      spt_pkg::CMD_INSERT: begin
        // slots at or above the insert point move right by one
        if (!lt_r) begin
          if (left.lt) begin
            key_nxt   = ctl.key;
            stamp_nxt = ctl.stamp;
          end else begin
            key_nxt   = left.key;
            stamp_nxt = left.stamp;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    stamp_r <= stamp_nxt;
    if (!rst_n) begin
      lt_r  <= 1'b0;
      eq_r  <= 1'b0;
      le_r  <= 1'b0;
      tok_r <= 1'b0;
    end else begin
      lt_r  <= lt_nxt;
      eq_r  <= eq_nxt;
      le_r  <= le_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_comb begin
    self_link.lt    = lt_r;
    self_link.tok   = tok_r;
    self_link.key   = key_r;
    self_link.stamp = stamp_r;

    tap.tok      = tok_r;
    tap.eq       = tok_r && eq_r;
    tap.inr      = tok_r && inr;
    tap.next_inr = tok_r && right_inr;
    tap.key      = tok_r ? key_r   : '0;
    tap.stamp    = tok_r ? stamp_r : '0;
  end

endmodule

`default_nettype wire

// ===== design/sorted_page_table_first_write.sv =====
// ----------------------------------------------------------------------------
// sorted_page_table_first_write
// Sorted page/timestamp table built as a row of record cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_* is a valid/ready channel carrying mode, page_key, range_end and
//   stamp. in_ready is high only while the block is idle; one transaction
//   is worked on at a time. out_* is a valid/ready channel with status,
//   page_out, stamp_out and last; a result sits in the output register
//   until taken, and a stalled receiver simply holds the walk.
//   Insert and lookup: accept, compare in every cell, arm the token at the
//   first slot not below the key, then one result once the output is free.
//   The insert shifts the slots at or above the insert point right by one
//   slot as that result is registered.
//   Range walk: the same set-up, then, while the output is free, the token
//   steps one cell and gives one record per cycle; last marks the final one.
//   An empty range gives a single range-empty result.
//   Mode 3 is dropped on acceptance with no result.
//   Reset empties the table at once (entry count to zero); no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_page_table_first_write #(
  parameter int CAPACITY = spt_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [spt_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [spt_pkg::KEY_W-1:0]     in_page_key,
  input  wire logic [spt_pkg::KEY_W-1:0]     in_range_end,
  input  wire logic [spt_pkg::STAMP_W-1:0]   in_stamp,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [spt_pkg::STATUS_W-1:0]       out_status,
  output logic [spt_pkg::KEY_W-1:0]          out_page_out,
  output logic [spt_pkg::STAMP_W-1:0]        out_stamp_out,
  output logic                               out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EVAL = 2'd1,
    S_ARM  = 2'd2,
    S_RUN  = 2'd3
  } state_t;

  state_t                      state_r, state_nxt;
  spt_pkg::mode_t              mode_r,  mode_nxt;
  logic [spt_pkg::KEY_W-1:0]   key_r,   key_nxt;
  logic [spt_pkg::KEY_W-1:0]   end_r,   end_nxt;
  logic [spt_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;

  logic                        out_valid_r,  out_valid_nxt;
  spt_pkg::status_t            out_status_r, out_status_nxt;
  logic [spt_pkg::KEY_W-1:0]   out_page_r,   out_page_nxt;
  logic [spt_pkg::STAMP_W-1:0] out_stamp_r,  out_stamp_nxt;
  logic                        out_last_r,   out_last_nxt;

  spt_pkg::cell_ctl_t  ctl;
  spt_pkg::cell_link_t links [CAPACITY];
  spt_pkg::cell_tap_t  taps  [CAPACITY];
  spt_pkg::cell_tap_t  bus;
  logic [CAPACITY-1:0] inr_vec;
  logic [CAPACITY-1:0] vld_vec;
  logic [CAPACITY-1:0] tok_vec;
  logic                out_free;
  logic                full;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spt_pkg::cell_link_t left_link;
    logic                right_inr;

    assign vld_vec[i] = count_r > CNT_W'(i);
    assign tok_vec[i] = links[i].tok;

    if (i == 0) begin : g_first
      assign left_link = '{lt: 1'b1, tok: 1'b0, key: '0, stamp: '0};
    end else begin : g_mid
      assign left_link = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_inr = 1'b0;
    end else begin : g_inner
      assign right_inr = inr_vec[i+1];
    end

    spt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .vld       (vld_vec[i]),
      .left      (left_link),
      .right_inr (right_inr),
      .self_link (links[i]),
      .inr       (inr_vec[i]),
      .tap       (taps[i])
    );
  end

  // only the token holder drives a non-zero tap
  always_comb begin
    bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      bus = bus | taps[i];
    end
  end

  // ---------------------------------------------------------------- control
  assign full     = count_r == CNT_W'(CAPACITY);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    end_nxt        = end_r;
    stamp_nxt      = stamp_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_stamp_nxt  = out_stamp_r;
    out_last_nxt   = out_last_r;

    ctl.cmd       = spt_pkg::CMD_HOLD;
    ctl.key       = key_r;
    ctl.range_end = end_r;
    ctl.stamp     = stamp_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = spt_pkg::mode_t'(in_mode);
          key_nxt   = in_page_key;
          end_nxt   = in_range_end;
          stamp_nxt = in_stamp;
          if (in_mode == spt_pkg::MODE_INSERT || in_mode == spt_pkg::MODE_LOOKUP ||
              in_mode == spt_pkg::MODE_RANGE) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        ctl.cmd   = spt_pkg::CMD_EVAL;
        state_nxt = S_ARM;
      end
      S_ARM: begin
        ctl.cmd   = spt_pkg::CMD_ARM;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_page_nxt  = '0;
          out_stamp_nxt = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
          case (mode_r)
            spt_pkg::MODE_INSERT: begin
              if (bus.eq) begin
                out_status_nxt = spt_pkg::STS_DUPLICATE;
              end else if (full) begin
                out_status_nxt = spt_pkg::STS_FULL;
              end else begin
                out_status_nxt = spt_pkg::STS_INSERTED;
                ctl.cmd        = spt_pkg::CMD_INSERT;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            spt_pkg::MODE_LOOKUP: begin
              if (bus.eq) begin
                out_status_nxt = spt_pkg::STS_HIT;
                out_page_nxt   = bus.key;
                out_stamp_nxt  = bus.stamp;
              end else begin
                out_status_nxt = spt_pkg::STS_MISS;
              end
            end
            spt_pkg::MODE_RANGE: begin
              if (bus.inr) begin
                out_status_nxt = spt_pkg::STS_RANGE_ENTRY;
                out_page_nxt   = bus.key;
                out_stamp_nxt  = bus.stamp;
                out_last_nxt   = !bus.next_inr;
                ctl.cmd        = spt_pkg::CMD_SHIFT;
                if (bus.next_inr) begin
                  state_nxt = S_RUN;
                end
              end else begin
                out_status_nxt = spt_pkg::STS_RANGE_EMPTY;
              end
            end
            default: begin
              out_valid_nxt = out_valid_r && !out_ready;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    end_r        <= end_nxt;
    stamp_r      <= stamp_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_stamp_r  <= out_stamp_nxt;
    out_last_r   <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_page_out  = out_page_r;
  assign out_stamp_out = out_stamp_r;
  assign out_last      = out_last_r;

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one cell holds the read token");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && ctl.cmd == spt_pkg::CMD_INSERT) |=>
      count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not bump the entry count");

  a_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !tok_vec[0] || state_r == S_IDLE)
    else $error("transaction accepted outside idle");

endmodule

`default_nettype wire
